>>> src/oblivious_tree_ensemble_eval_top_assert.svh
// Assertion macros shared by the ensemble evaluator RTL.
// Used by oblivious_tree_ensemble_eval_top; expects clk and rst_n in scope.
`ifndef OBLIVIOUS_TREE_ENSEMBLE_EVAL_TOP_ASSERT_SVH
`define OBLIVIOUS_TREE_ENSEMBLE_EVAL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OTEE_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("otee assertion failed");
`define OTEE_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("otee assertion failed");
`else
`define OTEE_ASSERT_IMP(label, pre, post)
`define OTEE_ASSERT_NXT(label, pre, post)
`endif
`endif

>>> src/otee_pkg.sv
// Shared types, codes and the sigmoid table for the ensemble evaluator.
// No dependencies; imported by otee_sigmoid and the top module of the block.
package otee_pkg;

    localparam int MAX_FEATURES_DEF = 256;
    localparam int MAX_BORDERS_DEF  = 1024;
    localparam int MAX_TREES_DEF    = 128;
    localparam int MAX_DEPTH_DEF    = 8;
    localparam int MAX_SPLITS_DEF   = 1024;
    localparam int MAX_LEAVES_DEF   = 32768;

    localparam logic [2:0] MODE_BORDER  = 3'd0;
    localparam logic [2:0] MODE_SPLIT   = 3'd1;
    localparam logic [2:0] MODE_LEAF    = 3'd2;
    localparam logic [2:0] MODE_DEPTH   = 3'd3;
    localparam logic [2:0] MODE_FEATURE = 3'd4;
    localparam logic [2:0] MODE_EVAL    = 3'd5;

    localparam logic [1:0] PT_RAW   = 2'd0;
    localparam logic [1:0] PT_PROB  = 2'd1;
    localparam logic [1:0] PT_CLASS = 2'd2;

    localparam logic REG_BORDER_COUNT = 1'b0;
    localparam logic REG_TREE_COUNT   = 1'b1;

    localparam int SPLIT_W = 11;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef struct packed {
        logic [2:0]         mode;
        logic [14:0]        address;
        logic [7:0]         border_feature;
        logic signed [31:0] value;
        logic [1:0]         prediction_type;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic               unsupported_type;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [47:0] sum;
    } sig_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] result;
    } sig_rsp_t;

    typedef logic [16:0] sig_tab_t [0:256];

    // Restoring long division, evaluated at elaboration only.
    function automatic logic [16:0] q_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q[16:0];
    endfunction

    function automatic sig_tab_t sig_build();
        sig_tab_t    tab;
        logic [16:0] pos [0:128];
        logic [63:0] p;
        logic [63:0] den;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            den    = (64'd1 << 32) + p;
            pos[k] = q_div((64'd1 << 48) + (den >> 1), den);
            p      = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i <= 256; i++) begin
            if (i >= 128)
                tab[i] = pos[i - 128];
            else
                tab[i] = 17'd65536 - pos[128 - i];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

>>> src/otee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module otee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> src/otee_sigmoid.sv
// Three-step sigmoid unit: table lookup, one multiply, rounded add.
// Depends on otee_pkg for the table and request/response structs.
module otee_sigmoid (
    input  logic              clk,
    input  logic              rst_n,
    input  otee_pkg::sig_req_t req,
    output otee_pkg::sig_rsp_t rsp
);
    import otee_pkg::*;

    localparam logic [1:0] SG_IDLE = 2'd0;
    localparam logic [1:0] SG_MUL  = 2'd1;
    localparam logic [1:0] SG_ADD  = 2'd2;

    localparam logic signed [47:0] LOW_LIM  = -(48'sd8 <<< 24);
    localparam logic signed [47:0] HIGH_LIM = (48'sd8 <<< 24);

    logic [1:0]  state_reg, state_next;
    logic [16:0] a_reg, a_next;
    logic [16:0] diff_reg, diff_next;
    logic [19:0] f_reg, f_next;
    logic [36:0] prod_reg;
    logic [16:0] res_reg;
    logic        done_reg;

    logic [47:0] u;
    logic [7:0]  ti;
    logic [16:0] ta, tb;

    always_comb
    begin
        u  = 48'(req.sum + HIGH_LIM);
        ti = u[27:20];
        ta = SIG_TABLE[ti];
        tb = SIG_TABLE[9'(ti) + 9'd1];
        a_next    = ta;
        diff_next = (tb > ta) ? (tb - ta) : 17'd0;
        f_next    = u[19:0];
        if (req.sum < LOW_LIM) begin
            a_next    = SIG_TABLE[0];
            diff_next = '0;
            f_next    = '0;
        end else if (req.sum >= HIGH_LIM) begin
            a_next    = SIG_TABLE[256];
            diff_next = '0;
            f_next    = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SG_IDLE: if (req.start) state_next = SG_MUL;
            SG_MUL:  state_next = SG_ADD;
            SG_ADD:  state_next = SG_IDLE;
            default: state_next = SG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= SG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SG_ADD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SG_IDLE && req.start) begin
            a_reg    <= a_next;
            diff_reg <= diff_next;
            f_reg    <= f_next;
        end
        if (state_reg == SG_MUL)
            prod_reg <= 37'(diff_reg) * 37'(f_reg);
        if (state_reg == SG_ADD)
            res_reg <= a_reg + 17'((prod_reg + 37'h80000) >> 20);
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;
endmodule

>>> src/oblivious_tree_ensemble_eval_top.sv
// Oblivious tree ensemble evaluator: table loading, sequencer and output register.
// Depends on otee_pkg, otee_ram, otee_sigmoid and the assertion macro header.
//
// Usage: the input channel (in_valid/in_stall/in_item) carries load items
// (border, split, leaf, tree depth, feature value) and evaluate items. An item
// is taken at a clock edge with in_valid high and in_stall low. Load and
// feature items can arrive back to back.
// An evaluate item holds in_stall high while a small sequencer walks the
// tables through single read ports: it compares each border in use, then per
// tree reads its depth, one split and its bit per level and a leaf, then closes
// the loops and finishes (via the sigmoid unit for a probability). The result item
// then sits in the output register (out_valid/out_stall/out_item) and stays
// there while the receiver stalls; the next item is taken once the result is
// loaded.
// The user must write border_count and tree_count over the APB port only while
// idle; the block does not enforce it. Reset clears both registers and all control
// state; the tables are undefined until written.
module oblivious_tree_ensemble_eval_top #(
    parameter int MAX_FEATURES = otee_pkg::MAX_FEATURES_DEF,
    parameter int MAX_BORDERS  = otee_pkg::MAX_BORDERS_DEF,
    parameter int MAX_TREES    = otee_pkg::MAX_TREES_DEF,
    parameter int MAX_DEPTH    = otee_pkg::MAX_DEPTH_DEF,
    parameter int MAX_SPLITS   = otee_pkg::MAX_SPLITS_DEF,
    parameter int MAX_LEAVES   = otee_pkg::MAX_LEAVES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  otee_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output otee_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import otee_pkg::*;
    `include "oblivious_tree_ensemble_eval_top_assert.svh"

    localparam int FA_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int BA_W  = (MAX_BORDERS > 1) ? $clog2(MAX_BORDERS) : 1;
    localparam int TA_W  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int SA_W  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam int LA_W  = $clog2(MAX_LEAVES);
    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam int J_W   = DEP_W;
    localparam int SP_W  = $clog2(256 * MAX_DEPTH + 1);
    localparam int LO_W  = 9 + MAX_DEPTH;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_B_ISSUE  = 4'd1;
    localparam logic [3:0] ST_B_FEAT   = 4'd2;
    localparam logic [3:0] ST_B_CMP    = 4'd3;
    localparam logic [3:0] ST_T_ISSUE  = 4'd4;
    localparam logic [3:0] ST_T_DEPTH  = 4'd5;
    localparam logic [3:0] ST_S_ISSUE  = 4'd6;
    localparam logic [3:0] ST_S_SPLIT  = 4'd7;
    localparam logic [3:0] ST_S_BIT    = 4'd8;
    localparam logic [3:0] ST_L_ISSUE  = 4'd9;
    localparam logic [3:0] ST_L_ADD    = 4'd10;
    localparam logic [3:0] ST_FINISH   = 4'd11;
    localparam logic [3:0] ST_SIG_WAIT = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    // Configuration registers.
    logic [10:0] border_count_reg;
    logic [7:0]  tree_count_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            border_count_reg <= '0;
            tree_count_reg   <= '0;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_BORDER_COUNT: border_count_reg <= pwdata[10:0];
                REG_TREE_COUNT:   tree_count_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BORDER_COUNT: prdata = 32'(border_count_reg);
            REG_TREE_COUNT:   prdata = 32'(tree_count_reg);
            default:          prdata = '0;
        endcase
    end

    logic [10:0] nb;
    logic [7:0]  nt;
    assign nb = (32'(border_count_reg) < MAX_BORDERS) ? border_count_reg : 11'(MAX_BORDERS);
    assign nt = (32'(tree_count_reg) < MAX_TREES) ? tree_count_reg : 8'(MAX_TREES);

    // Sequencer registers.
    logic [3:0]         state_reg, state_next;
    logic [1:0]         ptype_reg;
    logic [10:0]        b_reg;
    logic [7:0]         t_reg;
    logic [J_W-1:0]     j_reg;
    logic [DEP_W-1:0]   depth_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [MAX_DEPTH-1:0] idx_reg;
    logic signed [47:0] sum_reg;
    logic signed [31:0] thr_reg;
    logic               own_ok_reg;
    logic               pos_ok_reg;
    logic               bit_ok_reg;
    logic               leaf_ok_reg;
    logic signed [47:0] res_reg;
    logic               unsup_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic in_acc, out_free;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Address and data formation.
    logic [31:0] addr32, uval;
    logic [31:0] b32, t32, pos32, split32, owner32, leaf32;
    logic [SP_W:0] pos;
    logic [LO_W-1:0] leaf_addr;

    assign addr32    = 32'(in_item.address);
    assign uval      = in_item.value;
    assign b32       = 32'(b_reg);
    assign t32       = 32'(t_reg);
    assign pos       = (SP_W + 1)'(sp_reg) + (SP_W + 1)'(j_reg);
    assign pos32     = 32'(pos);
    assign leaf_addr = lo_reg + LO_W'(idx_reg);
    assign leaf32    = 32'(leaf_addr);

    // Table memories.
    logic [39:0]        brd_rdata;
    logic [31:0]        feat_rdata;
    logic               bit_rdata;
    logic [SPLIT_W-1:0] spl_rdata;
    logic [DEP_W-1:0]   dep_rdata;
    logic [31:0]        leaf_rdata;
    logic [SPLIT_W-1:0] spl_wdata;
    logic [DEP_W-1:0]   dep_wdata;
    logic               bit_we, bit_wdata;
    logic signed [31:0] fv;

    assign owner32   = 32'(brd_rdata[39:32]);
    assign split32   = 32'(spl_rdata);
    assign spl_wdata = (uval > 32'(2 ** SPLIT_W - 1)) ? {SPLIT_W{1'b1}} : uval[SPLIT_W-1:0];
    assign dep_wdata = (uval > 32'(MAX_DEPTH)) ? DEP_W'(MAX_DEPTH) : uval[DEP_W-1:0];
    assign fv        = own_ok_reg ? feat_rdata : 32'sd0;
    assign bit_we    = (state_reg == ST_B_CMP);
    assign bit_wdata = (fv > thr_reg);

    otee_ram #(.WIDTH(40), .DEPTH(MAX_BORDERS)) u_border_ram (
        .clk   (clk),
        .we    (in_acc && in_item.mode == MODE_BORDER && addr32 < MAX_BORDERS),
        .waddr (addr32[BA_W-1:0]),
        .wdata ({in_item.border_feature, in_item.value}),
        .raddr (b32[BA_W-1:0]),
        .rdata (brd_rdata)
    );

    otee_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_feature_ram (
        .clk   (clk),
        .we    (in_acc && in_item.mode == MODE_FEATURE && addr32 < MAX_FEATURES),
        .waddr (addr32[FA_W-1:0]),
        .wdata (in_item.value),
        .raddr (owner32[FA_W-1:0]),
        .rdata (feat_rdata)
    );

    otee_ram #(.WIDTH(1), .DEPTH(MAX_BORDERS)) u_bit_ram (
        .clk   (clk),
        .we    (bit_we),
        .waddr (b32[BA_W-1:0]),
        .wdata (bit_wdata),
        .raddr (split32[BA_W-1:0]),
        .rdata (bit_rdata)
    );

    otee_ram #(.WIDTH(SPLIT_W), .DEPTH(MAX_SPLITS)) u_split_ram (
        .clk   (clk),
        .we    (in_acc && in_item.mode == MODE_SPLIT && addr32 < MAX_SPLITS),
        .waddr (addr32[SA_W-1:0]),
        .wdata (spl_wdata),
        .raddr (pos32[SA_W-1:0]),
        .rdata (spl_rdata)
    );

    otee_ram #(.WIDTH(DEP_W), .DEPTH(MAX_TREES)) u_depth_ram (
        .clk   (clk),
        .we    (in_acc && in_item.mode == MODE_DEPTH && addr32 < MAX_TREES),
        .waddr (addr32[TA_W-1:0]),
        .wdata (dep_wdata),
        .raddr (t32[TA_W-1:0]),
        .rdata (dep_rdata)
    );

    otee_ram #(.WIDTH(32), .DEPTH(MAX_LEAVES)) u_leaf_ram (
        .clk   (clk),
        .we    (in_acc && in_item.mode == MODE_LEAF && addr32 < MAX_LEAVES),
        .waddr (addr32[LA_W-1:0]),
        .wdata (in_item.value),
        .raddr (leaf32[LA_W-1:0]),
        .rdata (leaf_rdata)
    );

    // Sigmoid unit.
    sig_req_t sig_req;
    sig_rsp_t sig_rsp;
    assign sig_req.start = (state_reg == ST_FINISH) && (ptype_reg == PT_PROB);
    assign sig_req.sum   = sum_reg;

    otee_sigmoid u_sigmoid (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sig_req),
        .rsp   (sig_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_acc && in_item.mode == MODE_EVAL) state_next = ST_B_ISSUE;
            ST_B_ISSUE:  state_next = (b_reg < nb) ? ST_B_FEAT : ST_T_ISSUE;
            ST_B_FEAT:   state_next = ST_B_CMP;
            ST_B_CMP:    state_next = ST_B_ISSUE;
            ST_T_ISSUE:  state_next = (t_reg < nt) ? ST_T_DEPTH : ST_FINISH;
            ST_T_DEPTH:  state_next = ST_S_ISSUE;
            ST_S_ISSUE:  state_next = (j_reg < depth_reg) ? ST_S_SPLIT : ST_L_ISSUE;
            ST_S_SPLIT:  state_next = ST_S_BIT;
            ST_S_BIT:    state_next = ST_S_ISSUE;
            ST_L_ISSUE:  state_next = ST_L_ADD;
            ST_L_ADD:    state_next = ST_T_ISSUE;
            ST_FINISH:   state_next = (ptype_reg == PT_PROB) ? ST_SIG_WAIT : ST_DONE;
            ST_SIG_WAIT: if (sig_rsp.done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                ptype_reg <= in_item.prediction_type;
                b_reg     <= '0;
                t_reg     <= '0;
                sp_reg    <= '0;
                lo_reg    <= '0;
                sum_reg   <= '0;
            end
            ST_B_FEAT:
            begin
                thr_reg    <= brd_rdata[31:0];
                own_ok_reg <= (owner32 < MAX_FEATURES);
            end
            ST_B_CMP:    b_reg <= b_reg + 11'd1;
            ST_T_DEPTH:
            begin
                depth_reg <= dep_rdata;
                j_reg     <= '0;
                idx_reg   <= '0;
            end
            ST_S_ISSUE:  pos_ok_reg <= (pos32 < MAX_SPLITS);
            ST_S_SPLIT:  bit_ok_reg <= pos_ok_reg && (split32 < 32'(nb));
            ST_S_BIT:
            begin
                if (bit_ok_reg && bit_rdata)
                    idx_reg <= idx_reg | (MAX_DEPTH'(1) << j_reg);
                j_reg <= j_reg + J_W'(1);
            end
            ST_L_ISSUE:  leaf_ok_reg <= (leaf32 < MAX_LEAVES);
            ST_L_ADD:
            begin
                if (leaf_ok_reg)
                    sum_reg <= sum_reg + 48'(signed'(leaf_rdata));
                sp_reg <= sp_reg + SP_W'(depth_reg);
                lo_reg <= lo_reg + (LO_W'(1) << depth_reg);
                t_reg  <= t_reg + 8'd1;
            end
            ST_FINISH:
            begin
                unsup_reg <= 1'b0;
                case (ptype_reg)
                    PT_RAW:   res_reg <= sum_reg;
                    PT_CLASS: res_reg <= (sum_reg > 48'sd0) ? 48'sd1 : 48'sd0;
                    PT_PROB:  res_reg <= '0;
                    default:
                    begin
                        res_reg   <= '0;
                        unsup_reg <= 1'b1;
                    end
                endcase
            end
            ST_SIG_WAIT: if (sig_rsp.done) res_reg <= 48'(sig_rsp.result);
            ST_DONE:
            begin
                if (out_free) begin
                    out_item_reg.result_value     <= res_reg;
                    out_item_reg.unsupported_type <= unsup_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `OTEE_ASSERT_NXT(a_eval_holds, in_acc && in_item.mode == MODE_EVAL, in_stall)
    `OTEE_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state_reg) == ST_DONE)
    `OTEE_ASSERT_IMP(a_sig_expected, sig_rsp.done, state_reg == ST_SIG_WAIT)
endmodule

>>> verif/tb_oblivious_tree_ensemble_eval_top.sv
// Self-checking testbench for oblivious_tree_ensemble_eval_top: loads tables, evaluates
// and checks every result against a predictor kept in step with accepted items.
// Depends on otee_pkg and the RTL of the block only.
module tb_oblivious_tree_ensemble_eval_top;
    timeunit 1ns;
    timeprecision 1ps;

    import otee_pkg::*;

    localparam int N_FEAT = 256;
    localparam int N_BRD = 1024;
    localparam int N_TREE = 128;
    localparam int N_DEPTH = 8;
    localparam int N_SPLIT = 1024;
    localparam int N_LEAF = 32768;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 40;
    localparam logic [1:0] PT_UNSUPPORTED = 2'd3;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam longint EIGHT_Q24 = 134217728;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    oblivious_tree_ensemble_eval_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Predictor copy of the block's tables and registers.
    logic signed [31:0] feat_v [N_FEAT];
    logic signed [31:0] thr_v [N_BRD];
    logic [7:0] own_v [N_BRD];
    logic [31:0] split_v [N_SPLIT];
    logic [3:0] depth_v [N_TREE];
    logic signed [31:0] leaf_v [N_LEAF];
    int cfg_borders = 0;
    int cfg_trees = 0;
    longint unsigned sig_lut [0:256];

    // What the stimulus side knows has been loaded, so no evaluate reads a blank entry.
    bit feat_wr [N_FEAT];
    bit brd_wr [N_BRD];
    bit spl_wr [N_SPLIT];
    bit dep_wr [N_TREE];
    bit leaf_wr [N_LEAF];
    logic [7:0] gen_own [N_BRD];
    int gen_depth [N_TREE];
    int gen_nb = 0;
    int gen_nt = 0;

    in_item_t pending_items [$];
    out_item_t want_results [$];
    int items_queued = 0;
    int items_taken = 0;
    int results_seen = 0;
    int n_mismatch = 0;
    int n_evals = 0;
    int n_settings = 0;
    int cyc = 0;
    int idle_cyc = 0;
    logic in_took = 1'b0;
    int in_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;

    function automatic int draw_gap();
        if (((cyc / 500) % 3) == 0)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned sigmoid_q16(longint s);
        longint unsigned u;
        longint unsigned f;
        longint unsigned a;
        longint unsigned b;
        int i;
        if (s < -EIGHT_Q24)
            return sig_lut[0];
        if (s >= EIGHT_Q24)
            return sig_lut[256];
        u = s + EIGHT_Q24;
        i = int'(u >> 20);
        f = u & 64'hFFFFF;
        a = sig_lut[i];
        b = sig_lut[i + 1];
        if (b < a)
            b = a;
        return a + (((b - a) * f + 64'h80000) >> 20);
    endfunction

    task automatic score_item(input in_item_t it);
        int nb;
        int nt;
        int sp;
        int lo;
        int d;
        int pos;
        int unsigned idx;
        bit bits [N_BRD];
        longint sum;
        out_item_t r;
        case (it.mode)
            MODE_BORDER:
                if (it.address < N_BRD)
                begin
                    thr_v[it.address] = it.value;
                    own_v[it.address] = it.border_feature;
                end
            MODE_SPLIT:
                if (it.address < N_SPLIT)
                    split_v[it.address] = it.value;
            MODE_LEAF:
                if (it.address < N_LEAF)
                    leaf_v[it.address] = it.value;
            MODE_DEPTH:
                if (it.address < N_TREE)
                    depth_v[it.address] = ($unsigned(it.value) > N_DEPTH) ? 4'(N_DEPTH)
                                                                          : it.value[3:0];
            MODE_FEATURE:
                if (it.address < N_FEAT)
                    feat_v[it.address] = it.value;
            MODE_EVAL:
            begin
                nb = cfg_borders > N_BRD ? N_BRD : cfg_borders;
                nt = cfg_trees > N_TREE ? N_TREE : cfg_trees;
                for (int b = 0; b < nb; b++)
                    bits[b] = feat_v[own_v[b]] > thr_v[b];
                sum = 0;
                sp = 0;
                lo = 0;
                for (int t = 0; t < nt; t++)
                begin
                    d = depth_v[t];
                    idx = 0;
                    for (int k = 0; k < d; k++)
                    begin
                        pos = sp + k;
                        if (pos < N_SPLIT && split_v[pos] < nb)
                            idx |= int'(bits[split_v[pos]]) << k;
                    end
                    if (lo + idx < N_LEAF)
                        sum += leaf_v[lo + idx];
                    sp += d;
                    lo += 1 << d;
                end
                r = '0;
                case (it.prediction_type)
                    PT_RAW: r.result_value = sum[47:0];
                    PT_PROB: r.result_value = 48'(sigmoid_q16(sum));
                    PT_CLASS: r.result_value = (sum > 0) ? 48'sd1 : 48'sd0;
                    default: r.unsupported_type = 1'b1;
                endcase
                want_results.push_back(r);
                n_evals++;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, field, got, want);
        n_mismatch++;
    endtask

    // Input side: acceptance, prediction and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                score_item(in_item);
                items_taken <= items_taken + 1;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_results.size() == 0)
                report_mismatch("unexpected item", out_item.result_value, 0);
            else
            begin
                if (out_item.result_value !== want_results[0].result_value)
                    report_mismatch("result_value", out_item.result_value,
                                    want_results[0].result_value);
                if (out_item.unsupported_type !== want_results[0].unsupported_type)
                    report_mismatch("unsupported_type", out_item.unsupported_type,
                                    want_results[0].unsupported_type);
                void'(want_results.pop_front());
            end
            results_seen <= results_seen + 1;
        end
    end

    // Item driver.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with one long hold-off so the block backs up into its input.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (!hold_done && results_seen >= 30)
        begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = draw_gap();
            out_stall <= (stall_left > 0);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic queue_item(input logic [2:0] m, input int a, input int o,
                              input logic [31:0] v, input logic [1:0] pt);
        in_item_t it;
        it.mode = m;
        it.address = a[14:0];
        it.border_feature = o[7:0];
        it.value = v;
        it.prediction_type = pt;
        case (m)
            MODE_BORDER:
                if (a < N_BRD)
                begin
                    brd_wr[a] = 1;
                    gen_own[a] = o[7:0];
                end
            MODE_SPLIT: if (a < N_SPLIT) spl_wr[a] = 1;
            MODE_LEAF: if (a < N_LEAF) leaf_wr[a] = 1;
            MODE_DEPTH:
                if (a < N_TREE)
                begin
                    dep_wr[a] = 1;
                    gen_depth[a] = (v > N_DEPTH) ? N_DEPTH : int'(v);
                end
            MODE_FEATURE: if (a < N_FEAT) feat_wr[a] = 1;
            default: ;
        endcase
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [31:0] draw_q();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    // Depths stay small so that leaf loading keeps the item count modest.
    function automatic logic [31:0] draw_depth();
        if (gen_nt > 32)
            return $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            7, 8, 9: return $urandom_range(3, 5);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic int draw_owner();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] draw_split();
        if (gen_nb == 0 || $urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 2047);
        return $urandom_range(0, gen_nb - 1);
    endfunction

    function automatic int draw_addr(input int hot);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 32767);
        return $urandom_range(0, hot - 1);
    endfunction

    // Load whatever the next evaluate will read and nobody has written yet.
    task automatic fill_tables();
        int sp;
        int lo;
        int d;
        sp = 0;
        lo = 0;
        for (int b = 0; b < gen_nb; b++)
        begin
            if (!brd_wr[b])
                queue_item(MODE_BORDER, b, draw_owner(), draw_q(), PT_RAW);
            if (!feat_wr[gen_own[b]])
                queue_item(MODE_FEATURE, gen_own[b], 0, draw_q(), PT_RAW);
        end
        for (int t = 0; t < gen_nt; t++)
        begin
            if (!dep_wr[t])
                queue_item(MODE_DEPTH, t, 0, draw_depth(), PT_RAW);
            d = gen_depth[t];
            for (int k = 0; k < d; k++)
                if (sp + k < N_SPLIT && !spl_wr[sp + k])
                    queue_item(MODE_SPLIT, sp + k, 0, draw_split(), PT_RAW);
            for (int i = 0; i < (1 << d); i++)
                if (lo + i < N_LEAF && !leaf_wr[lo + i])
                    queue_item(MODE_LEAF, lo + i, 0, draw_q(), PT_RAW);
            sp += d;
            lo += 1 << d;
        end
    endtask

    task automatic queue_eval(input logic [1:0] pt);
        fill_tables();
        queue_item(MODE_EVAL, $urandom_range(0, 32767), $urandom_range(0, 255), $urandom(), pt);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            queue_eval(($urandom_range(0, 9) == 0) ? PT_UNSUPPORTED : 2'($urandom_range(0, 2)));
        else if (r < 45)
            queue_item(MODE_FEATURE, draw_addr(16), 0, draw_q(), 2'($urandom()));
        else if (r < 60)
            queue_item(MODE_BORDER, draw_addr(gen_nb > 0 ? gen_nb : N_BRD), draw_owner(),
                       draw_q(), 2'($urandom()));
        else if (r < 72)
            queue_item(MODE_LEAF, draw_addr(64), 0, draw_q(), 2'($urandom()));
        else if (r < 82)
            queue_item(MODE_SPLIT, draw_addr(64), 0, draw_split(), 2'($urandom()));
        else if (r < 92)
            queue_item(MODE_DEPTH, draw_addr(gen_nt > 0 ? gen_nt : N_TREE), 0, draw_depth(),
                       2'($urandom()));
        else
            queue_item(($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B,
                       $urandom_range(0, 32767), $urandom_range(0, 255), $urandom(),
                       2'($urandom()));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(items_taken == items_queued && want_results.size() == 0));
        // Load items give no result, so let the last one settle.
        repeat (10) @(negedge clk);
    endtask

    task automatic apb_write(input logic reg_index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input int bc, input int tc);
        wait_drained();
        apb_write(REG_BORDER_COUNT, bc);
        apb_write(REG_TREE_COUNT, tc);
        cfg_borders = bc & 'h7FF;
        cfg_trees = tc & 'hFF;
        gen_nb = cfg_borders > N_BRD ? N_BRD : cfg_borders;
        gen_nt = cfg_trees > N_TREE ? N_TREE : cfg_trees;
        n_settings++;
    endtask

    initial
    begin
        longint unsigned p;
        longint unsigned den;
        longint unsigned pos_tab [0:128];
        int settings_bc [6];
        int settings_tc [6];
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++)
        begin
            den = (64'd1 << 32) + p;
            pos_tab[k] = ((64'd1 << 48) + (den >> 1)) / den;
            p = (p * 64'd4034748382 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i <= 256; i++)
            sig_lut[i] = (i >= 128) ? pos_tab[i - 128] : 65536 - pos_tab[128 - i];

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty ensemble: every type on a zero sum, plus ignored and out-of-range items.
        set_config(0, 0);
        for (int t = 0; t < 4; t++)
            queue_eval(2'(t));
        queue_item(MODE_SPARE_A, 0, 0, 32'hFFFF_FFFF, PT_RAW);
        queue_item(MODE_SPARE_B, 32767, 255, 32'h0, PT_UNSUPPORTED);
        queue_item(MODE_BORDER, N_BRD, 3, 32'h1234, PT_RAW);
        queue_item(MODE_SPLIT, 32767, 0, 32'h5, PT_RAW);
        queue_item(MODE_DEPTH, N_TREE, 0, 32'h3, PT_RAW);
        queue_item(MODE_FEATURE, N_FEAT, 0, 32'h7FFF_FFFF, PT_RAW);
        queue_item(MODE_LEAF, 32767, 0, 32'h8000_0000, PT_RAW);

        // Small ensemble with a threshold tie, sign extremes and a saturated depth.
        set_config(6, 3);
        queue_item(MODE_FEATURE, 0, 0, 32'h7FFF_FFFF, PT_RAW);
        queue_item(MODE_FEATURE, 1, 0, 32'h8000_0000, PT_RAW);
        queue_item(MODE_FEATURE, 255, 0, 32'h0, PT_RAW);
        queue_item(MODE_BORDER, 0, 0, 32'h7FFF_FFFE, PT_RAW);
        queue_item(MODE_BORDER, 1, 1, 32'h8000_0000, PT_RAW);
        queue_item(MODE_BORDER, 2, 255, 32'hFFFF_FFFF, PT_RAW);
        queue_item(MODE_DEPTH, 0, 0, 32'd2, PT_RAW);
        queue_item(MODE_DEPTH, 1, 0, 32'd100, PT_RAW);
        queue_item(MODE_DEPTH, 2, 0, 32'd0, PT_RAW);
        queue_item(MODE_SPLIT, 0, 0, 32'd0, PT_RAW);
        queue_item(MODE_SPLIT, 1, 0, 32'd2, PT_RAW);
        queue_item(MODE_SPLIT, 2, 0, 32'd6, PT_RAW);
        queue_item(MODE_SPLIT, 3, 0, 32'hFFFF_FFFF, PT_RAW);
        for (int t = 0; t < 4; t++)
            queue_eval(2'(t));

        // The tree count above the table size checks that it is clamped.
        settings_bc = '{6, 40, 1, 24, 17, 0};
        settings_tc = '{3, 8, 1, 160, 12, 0};
        for (int s = 0; s < 6; s++)
        begin
            set_config(settings_bc[s], settings_tc[s]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
        end
        wait_drained();

        $display("ran %0d items over %0d register settings; %0d evaluates, %0d results checked",
                 items_taken, n_settings, n_evals, results_seen);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
